@@ hw/rtl/fpalu_pkg.sv @@
// Shared constants and opcode type for the fixed-point ALU.
`default_nettype none
package fpalu_pkg;
  localparam int FRAC_BITS = 8;
  localparam int DW = 32 + FRAC_BITS;   // dividend width after pre-shift
  localparam int DIV_STAGES = DW;       // one quotient bit per stage

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_GT       = 4'd6,
    OP_LT       = 4'd7,
    OP_LE       = 4'd8,
    OP_GE       = 4'd9,
    OP_EQ       = 4'd10,
    OP_NE       = 4'd11,
    OP_MIN      = 4'd12,
    OP_MAX      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } opcode_t;
endpackage
`default_nettype wire

@@ hw/rtl/fixed_point_alu_top.sv @@
// Top level of the pipelined signed fixed-point ALU.
// Throughput: one transaction per cycle unless a held output stalls the pipe.
// Every opcode passes through all stages; the restoring divider retires one
// quotient bit per stage, so its chain of DIV_STAGES stages sets the latency.
// A stall of a valid output freezes the whole pipeline, nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload holds no reset.
`default_nettype none
module fixed_point_alu_top
  import fpalu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [3:0]  in_opcode,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic                    out_compare_true,
  output logic                    out_divide_by_zero
);

  // Advance every stage together unless a finished transaction is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 0: input register.
  logic               s0_valid_r;
  opcode_t            s0_op_r;
  logic signed [31:0] s0_a_r, s0_b_r;

  // Stage 1: product, operand magnitudes and simple results.
  logic               s1_valid_r;
  opcode_t            s1_op_r;
  logic signed [63:0] s1_prod_r;
  logic        [31:0] s1_res_r;
  logic               s1_cmp_r;
  logic        [DW-1:0] s1_un_r;
  logic        [31:0] s1_ud_r;
  logic               s1_negq_r;
  logic               s1_dz_r;

  logic        [31:0] s1_res_nxt;
  logic               s1_cmp_nxt;
  logic        [31:0] abs_a, abs_b;
  logic signed [31:0] to_int_bias;

  always_comb begin
    abs_a = s0_a_r[31] ? (32'd0 - s0_a_r) : s0_a_r;
    abs_b = s0_b_r[31] ? (32'd0 - s0_b_r) : s0_b_r;
    // Bias negatives so the arithmetic shift truncates toward zero.
    to_int_bias = s0_a_r + (s0_a_r[31] ? 32'((1 << FRAC_BITS) - 1) : 32'd0);
    s1_res_nxt = '0;
    s1_cmp_nxt = 1'b0;
    unique case (s0_op_r)
      OP_ADD:      s1_res_nxt = s0_a_r + s0_b_r;
      OP_SUB:      s1_res_nxt = s0_a_r - s0_b_r;
      OP_INC:      s1_res_nxt = s0_a_r + 32'd1;
      OP_DEC:      s1_res_nxt = s0_a_r - 32'd1;
      OP_GT:       s1_cmp_nxt = s0_a_r > s0_b_r;
      OP_LT:       s1_cmp_nxt = s0_a_r < s0_b_r;
      OP_LE:       s1_cmp_nxt = s0_a_r <= s0_b_r;
      OP_GE:       s1_cmp_nxt = s0_a_r >= s0_b_r;
      OP_EQ:       s1_cmp_nxt = s0_a_r == s0_b_r;
      OP_NE:       s1_cmp_nxt = s0_a_r != s0_b_r;
      OP_MIN:      s1_res_nxt = (s0_a_r < s0_b_r) ? s0_a_r : s0_b_r;
      OP_MAX:      s1_res_nxt = (s0_a_r < s0_b_r) ? s0_b_r : s0_a_r;
      OP_TO_INT:   s1_res_nxt = to_int_bias >>> FRAC_BITS;
      OP_FROM_INT: s1_res_nxt = s0_a_r << FRAC_BITS;
      OP_MUL, OP_DIV: s1_res_nxt = '0;  // filled in later stages
      default:     s1_res_nxt = '0;
    endcase
  end

  // Divider chain: entry d[0], one restoring step per stage.
  logic            d_valid_r [0:DIV_STAGES];
  opcode_t         d_op_r    [0:DIV_STAGES];
  logic [31:0]     d_res_r   [0:DIV_STAGES];
  logic            d_cmp_r   [0:DIV_STAGES];
  logic [31:0]     d_rem_r   [0:DIV_STAGES];
  logic [DW-1:0]   d_nq_r    [0:DIV_STAGES];
  logic [31:0]     d_ud_r    [0:DIV_STAGES];
  logic            d_negq_r  [0:DIV_STAGES];
  logic            d_dz_r    [0:DIV_STAGES];

  logic [31:0]     d_rem_nxt [0:DIV_STAGES-1];
  logic [DW-1:0]   d_nq_nxt  [0:DIV_STAGES-1];
  logic [32:0]     d_shift   [0:DIV_STAGES-1];
  logic [32:0]     d_diff    [0:DIV_STAGES-1];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      d_shift[k] = {d_rem_r[k], d_nq_r[k][DW-1]};
      d_diff[k]  = d_shift[k] - {1'b0, d_ud_r[k]};
      if (!d_diff[k][32]) begin
        d_rem_nxt[k] = d_diff[k][31:0];
        d_nq_nxt[k]  = {d_nq_r[k][DW-2:0], 1'b1};
      end else begin
        d_rem_nxt[k] = d_shift[k][31:0];
        d_nq_nxt[k]  = {d_nq_r[k][DW-2:0], 1'b0};
      end
    end
  end

  // Output stage: sign fix of the quotient and final select.
  logic [31:0] quo;
  logic [31:0] out_res_nxt;
  always_comb begin
    quo = d_nq_r[DIV_STAGES][31:0];
    if (d_op_r[DIV_STAGES] == OP_DIV) begin
      if (d_dz_r[DIV_STAGES])      out_res_nxt = '0;
      else if (d_negq_r[DIV_STAGES]) out_res_nxt = 32'd0 - quo;
      else                          out_res_nxt = quo;
    end else begin
      out_res_nxt = d_res_r[DIV_STAGES];
    end
  end

  // Valid bits: cleared by reset, advance with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) d_valid_r[k] <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      s0_valid_r   <= in_valid;
      s1_valid_r   <= s0_valid_r;
      d_valid_r[0] <= s1_valid_r;
      for (int k = 0; k < DIV_STAGES; k++) d_valid_r[k+1] <= d_valid_r[k];
      out_valid    <= d_valid_r[DIV_STAGES];
    end
  end

  // Payload: no reset, hold on stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op_r <= opcode_t'(in_opcode);
      s0_a_r  <= in_operand_a;
      s0_b_r  <= in_operand_b;

      s1_op_r   <= s0_op_r;
      s1_prod_r <= s0_a_r * s0_b_r;
      s1_res_r  <= s1_res_nxt;
      s1_cmp_r  <= s1_cmp_nxt;
      s1_un_r   <= {abs_a, {FRAC_BITS{1'b0}}};
      s1_ud_r   <= abs_b;
      s1_negq_r <= s0_a_r[31] ^ s0_b_r[31];
      s1_dz_r   <= (s0_op_r == OP_DIV) && (s0_b_r == 32'sd0);

      d_op_r[0]   <= s1_op_r;
      d_res_r[0]  <= (s1_op_r == OP_MUL) ? s1_prod_r[31+FRAC_BITS:FRAC_BITS] : s1_res_r;
      d_cmp_r[0]  <= s1_cmp_r;
      d_rem_r[0]  <= '0;
      d_nq_r[0]   <= s1_un_r;
      d_ud_r[0]   <= s1_ud_r;
      d_negq_r[0] <= s1_negq_r;
      d_dz_r[0]   <= s1_dz_r;

      for (int k = 0; k < DIV_STAGES; k++) begin
        d_op_r[k+1]   <= d_op_r[k];
        d_res_r[k+1]  <= d_res_r[k];
        d_cmp_r[k+1]  <= d_cmp_r[k];
        d_rem_r[k+1]  <= d_rem_nxt[k];
        d_nq_r[k+1]   <= d_nq_nxt[k];
        d_ud_r[k+1]   <= d_ud_r[k];
        d_negq_r[k+1] <= d_negq_r[k];
        d_dz_r[k+1]   <= d_dz_r[k];
      end

      out_result_value   <= out_res_nxt;
      out_compare_true   <= d_cmp_r[DIV_STAGES];
      out_divide_by_zero <= d_dz_r[DIV_STAGES];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fpalu_checker.sv @@
// Port-level assertions for the fixed-point ALU and their bind.
`default_nettype none
module fpalu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_result_value,
  input wire logic        out_compare_true,
  input wire logic        out_divide_by_zero
);

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Input stalls only while a finished transaction is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without held output");

  // Held output stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_value)
      && $stable(out_compare_true) && $stable(out_divide_by_zero)))
    else $error("held transaction changed");

  // Divide by zero gives a zero word and no compare flag.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result_value == 32'd0 && !out_compare_true))
    else $error("divide by zero result not clean");

endmodule

bind fixed_point_alu_top fpalu_checker u_fpalu_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_result_value(out_result_value),
  .out_compare_true(out_compare_true),
  .out_divide_by_zero(out_divide_by_zero)
);
`default_nettype wire
